// ----- hw/rtl/apd_pkg.sv -----
// Package for the addressed packet deframer: frame constants and result type.
// Depends on nothing; used by apd_parser, apd_out_stage, the top level and the bench.
package apd_pkg;

  localparam int unsigned MaxPayload = 16;
  localparam int unsigned LenW       = 5;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned StoreDepth = 16;

  localparam logic [7:0] SofByte    = 8'hAA;
  localparam logic [3:0] TargetTag  = 4'hD;
  localparam logic [3:0] SourceTag  = 4'hE;
  localparam logic [3:0] CkOnNibble = 4'hA;
  localparam logic [3:0] CkOffNibble = 4'h9;

  localparam logic StatusGood     = 1'b0;
  localparam logic StatusMismatch = 1'b1;

  localparam int unsigned DataW = 160;
  localparam int unsigned UserW = 2;

  typedef struct packed {
    logic            checksum_skipped;
    logic            frame_status;
    logic [7:0]      trailer_byte;
    logic [63:0]     payload_high;
    logic [63:0]     payload_low;
    logic [LenW-1:0] payload_length;
    logic [7:0]      packet_id;
    logic [3:0]      source_id;
    logic [3:0]      target_id;
  } result_t;

endpackage

// ----- hw/rtl/apd_in_stage.sv -----
// Input register of the deframer: holds one received byte until the parser takes it.
// Depends on no other file; uses nothing from apd_pkg.
module apd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] s_data_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] data_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       load;

  assign s_ready_o = !valid_q || take_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= s_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- hw/rtl/apd_parser.sv -----
// Frame parser: per-byte header/body state machine, running sum and payload store.
// Depends on apd_pkg for frame constants and the result struct.
module apd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  output logic             res_valid_o,
  output apd_pkg::result_t res_o
);

  typedef enum logic [2:0] {
    PhHunt, PhTarget, PhSource, PhId, PhLen, PhBody, PhTrailer
  } phase_e;

  phase_e                   phase_q, phase_d;
  logic [3:0]               target_q, target_d;
  logic [3:0]               source_q, source_d;
  logic [7:0]               id_q, id_d;
  logic [apd_pkg::LenW-1:0] total_q, total_d;
  logic [apd_pkg::LenW-1:0] seen_q, seen_d;
  logic [7:0]               sum_q, sum_d;
  logic [7:0]               store_q [apd_pkg::StoreDepth];
  logic [7:0]               store_d [apd_pkg::StoreDepth];
  logic                     ck_off_q, ck_off_d;

  logic       emit;
  logic [7:0] trailer;
  logic       status;
  logic       skipped;

  always_comb begin
    phase_d  = phase_q;
    target_d = target_q;
    source_d = source_q;
    id_d     = id_q;
    total_d  = total_q;
    seen_d   = seen_q;
    sum_d    = sum_q;
    store_d  = store_q;
    ck_off_d = ck_off_q;
    emit     = 1'b0;
    trailer  = 8'h00;
    status   = apd_pkg::StatusGood;
    skipped  = 1'b0;
    if (step_i) begin
      unique case (phase_q)
        PhHunt: begin
          if (byte_i == apd_pkg::SofByte) begin
            for (int i = 0; i < apd_pkg::StoreDepth; i++) begin
              store_d[i] = 8'h00;
            end
            target_d = 4'h0;
            source_d = 4'h0;
            id_d     = 8'h00;
            total_d  = '0;
            seen_d   = '0;
            sum_d    = byte_i;
            phase_d  = PhTarget;
          end
        end
        PhTarget: begin
          if (byte_i[7:4] != apd_pkg::TargetTag) begin
            phase_d = PhHunt;
          end else begin
            target_d = byte_i[3:0];
            sum_d    = sum_q + byte_i;
            phase_d  = PhSource;
          end
        end
        PhSource: begin
          if (byte_i[7:4] != apd_pkg::SourceTag) begin
            phase_d = PhHunt;
          end else begin
            source_d = byte_i[3:0];
            if (byte_i[3:0] == apd_pkg::CkOnNibble) begin
              ck_off_d = 1'b0;
            end else if (byte_i[3:0] == apd_pkg::CkOffNibble) begin
              ck_off_d = 1'b1;
            end
            sum_d   = sum_q + byte_i;
            phase_d = PhId;
          end
        end
        PhId: begin
          id_d    = byte_i;
          sum_d   = sum_q + byte_i;
          phase_d = PhLen;
        end
        PhLen: begin
          if (byte_i > 8'(apd_pkg::MaxPayload)) begin
            phase_d = PhHunt;
          end else begin
            total_d = byte_i[apd_pkg::LenW-1:0];
            seen_d  = '0;
            if (byte_i == 8'h00) begin
              // empty body: the length byte is the checked byte
              if (!ck_off_q && byte_i != sum_q) begin
                phase_d = PhHunt;
                emit    = 1'b1;
                status  = apd_pkg::StatusMismatch;
              end else begin
                phase_d = PhTrailer;
              end
            end else begin
              sum_d   = sum_q + byte_i;
              phase_d = PhBody;
            end
          end
        end
        PhBody: begin
          store_d[seen_q[apd_pkg::IdxW-1:0]] = byte_i;
          seen_d = seen_q + 1'b1;
          if (seen_d >= total_q) begin
            if (!ck_off_q && byte_i != sum_q) begin
              phase_d = PhHunt;
              emit    = 1'b1;
              status  = apd_pkg::StatusMismatch;
            end else begin
              phase_d = PhTrailer;
            end
          end else begin
            sum_d = sum_q + byte_i;
          end
        end
        PhTrailer: begin
          phase_d = PhHunt;
          emit    = 1'b1;
          trailer = byte_i;
          skipped = ck_off_q;
        end
        default: begin
          phase_d = PhHunt;
        end
      endcase
    end
  end

  always_comb begin
    res_o.target_id        = target_d;
    res_o.source_id        = source_d;
    res_o.packet_id        = id_d;
    res_o.payload_length   = total_d;
    res_o.trailer_byte     = trailer;
    res_o.frame_status     = status;
    res_o.checksum_skipped = skipped;
    for (int i = 0; i < 8; i++) begin
      res_o.payload_low[8*i +: 8]  = store_d[i];
      res_o.payload_high[8*i +: 8] = store_d[i+8];
    end
  end

  assign res_valid_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt;
      target_q <= 4'h0;
      source_q <= 4'h0;
      id_q     <= 8'h00;
      total_q  <= '0;
      seen_q   <= '0;
      sum_q    <= 8'h00;
      ck_off_q <= 1'b0;
      for (int i = 0; i < apd_pkg::StoreDepth; i++) begin
        store_q[i] <= 8'h00;
      end
    end else begin
      phase_q  <= phase_d;
      target_q <= target_d;
      source_q <= source_d;
      id_q     <= id_d;
      total_q  <= total_d;
      seen_q   <= seen_d;
      sum_q    <= sum_d;
      ck_off_q <= ck_off_d;
      store_q  <= store_d;
    end
  end

endmodule

// ----- hw/rtl/apd_out_stage.sv -----
// Result register of the deframer: holds one frame result until the sink takes it.
// Depends on apd_pkg for the result struct.
module apd_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  apd_pkg::result_t res_i,
  output logic             free_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output apd_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  apd_pkg::result_t res_q;

  // slot can be refilled in the same cycle the held word leaves
  assign free_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign res_o     = res_q;

endmodule

// ----- hw/rtl/addressed_packet_deframer_top.sv -----
// Top level of the addressed packet deframer: input register, parser, result register.
// Depends on apd_pkg, apd_in_stage, apd_parser and apd_out_stage.
//
//   channel  | dir | handshake              | payload
//   ---------+-----+------------------------+-----------------------------------
//   s_axis   | in  | tvalid/tready          | tdata[7:0] rx_byte
//   m_axis   | out | tvalid/tready          | tdata: header, payload, trailer
//            |     |                        | tuser: frame_status, checksum_skipped
//
// One byte per cycle sustained while the sink keeps up; a byte waits in the input register
// until it is parsed, and its result (if any) appears in the result register the next cycle.
// Reset puts the parser in start-byte hunt with the checksum enabled.
// A stalled sink holds the result register; the parser stops only while that
// register is full and not being taken, then the input register backs up.
module addressed_packet_deframer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [7:0] rx_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [3:0] target_id, [7:4] source_id, [15:8] packet_id, [20:16] payload_length,
  // [84:21] payload_low, [148:85] payload_high, [156:149] trailer_byte, rest zero
  output logic [apd_pkg::DataW-1:0]   m_axis_tdata,
  // [0] frame_status, [1] checksum_skipped
  output logic [apd_pkg::UserW-1:0]   m_axis_tuser
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             out_free;
  logic             step;
  logic             res_valid;
  apd_pkg::result_t res;
  apd_pkg::result_t res_out;

  assign step = in_valid && out_free;

  apd_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .take_i    (step),
    .valid_o   (in_valid),
    .data_o    (in_byte)
  );

  apd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  apd_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (res_valid),
    .res_i     (res),
    .free_o    (out_free),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .res_o     (res_out)
  );

  assign m_axis_tdata = {3'b000,
                         res_out.trailer_byte,
                         res_out.payload_high,
                         res_out.payload_low,
                         res_out.payload_length,
                         res_out.packet_id,
                         res_out.source_id,
                         res_out.target_id};
  assign m_axis_tuser = {res_out.checksum_skipped, res_out.frame_status};

endmodule

// ----- verif/tb_addressed_packet_deframer_top.sv -----
// Self-checking bench for addressed_packet_deframer_top: streams bytes, predicts frames.
// Depends on apd_pkg and the deframer RTL; drives s_axis, checks m_axis words in order.
`timescale 1ns / 1ps

module tb_addressed_packet_deframer_top;

  localparam int unsigned PackedW   = 157;  // tdata bits that carry fields
  localparam int unsigned StallLim  = 4000;
  localparam int unsigned DrainWait = 8;

  typedef enum logic [2:0] {
    PhHunt, PhTarget, PhSource, PhId, PhLen, PhBody, PhTrailer
  } parse_ph_e;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [7:0]                  s_axis_tdata = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [apd_pkg::DataW-1:0]   m_axis_tdata;
  logic [apd_pkg::UserW-1:0]   m_axis_tuser;

  addressed_packet_deframer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [7:0]        rx_bytes[$];
  apd_pkg::result_t  expected_frames[$];
  int unsigned       bytes_taken = 0;
  int unsigned       mismatches = 0;
  int unsigned       quiet_cycles = 0;

  // deframer shadow state
  parse_ph_e  ph = PhHunt;
  logic [3:0] tgt_nib = '0;
  logic [3:0] src_nib = '0;
  logic [7:0] pkt_id = '0;
  logic [4:0] len_total = '0;
  logic [4:0] len_seen = '0;
  logic [7:0] frame_sum = '0;
  logic [7:0] body_bytes[apd_pkg::MaxPayload] = '{default: '0};
  logic       ck_off = 1'b0;

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  function automatic apd_pkg::result_t frame_result(input logic [7:0] trailer,
                                                    input logic status,
                                                    input logic skipped);
    apd_pkg::result_t r;
    r = '0;
    r.target_id      = tgt_nib;
    r.source_id      = src_nib;
    r.packet_id      = pkt_id;
    r.payload_length = len_total;
    for (int i = 0; i < 8; i++) begin
      r.payload_low[8*i +: 8]  = body_bytes[i];
      r.payload_high[8*i +: 8] = body_bytes[i+8];
    end
    r.trailer_byte     = trailer;
    r.frame_status     = status;
    r.checksum_skipped = skipped;
    return r;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    case (ph)
      PhHunt: begin
        if (b == apd_pkg::SofByte) begin
          body_bytes = '{default: '0};
          tgt_nib   = '0;
          src_nib   = '0;
          pkt_id    = '0;
          len_total = '0;
          len_seen  = '0;
          frame_sum = b;
          ph        = PhTarget;
        end
      end
      PhTarget: begin
        if (b[7:4] != apd_pkg::TargetTag) begin
          ph = PhHunt;
        end else begin
          tgt_nib   = b[3:0];
          frame_sum = frame_sum + b;
          ph        = PhSource;
        end
      end
      PhSource: begin
        if (b[7:4] != apd_pkg::SourceTag) begin
          ph = PhHunt;
        end else begin
          src_nib = b[3:0];
          if (src_nib == apd_pkg::CkOnNibble) ck_off = 1'b0;
          else if (src_nib == apd_pkg::CkOffNibble) ck_off = 1'b1;
          frame_sum = frame_sum + b;
          ph        = PhId;
        end
      end
      PhId: begin
        pkt_id    = b;
        frame_sum = frame_sum + b;
        ph        = PhLen;
      end
      PhLen: begin
        if (b > apd_pkg::MaxPayload) begin
          ph = PhHunt;
        end else begin
          len_total = b[4:0];
          len_seen  = '0;
          if (b == 8'd0) begin
            // zero length: the length byte itself is the checked byte
            if (!ck_off && b != frame_sum) begin
              ph = PhHunt;
              expected_frames.push_back(
                frame_result(8'h00, apd_pkg::StatusMismatch, 1'b0));
            end else begin
              ph = PhTrailer;
            end
          end else begin
            frame_sum = frame_sum + b;
            ph        = PhBody;
          end
        end
      end
      PhBody: begin
        body_bytes[len_seen[3:0]] = b;
        len_seen = len_seen + 5'd1;
        if (len_seen >= len_total) begin
          if (!ck_off && b != frame_sum) begin
            ph = PhHunt;
            expected_frames.push_back(frame_result(8'h00, apd_pkg::StatusMismatch, 1'b0));
          end else begin
            ph = PhTrailer;
          end
        end else begin
          frame_sum = frame_sum + b;
        end
      end
      PhTrailer: begin
        ph = PhHunt;
        expected_frames.push_back(frame_result(b, apd_pkg::StatusGood, ck_off));
      end
      default: ph = PhHunt;
    endcase
  endtask

  // Full frame; the last counted byte is the running sum unless corrupt is set.
  // A clean zero-length frame gets its packet id chosen so the header sums to zero.
  task automatic queue_frame(input logic [3:0] tgt, input logic [3:0] src, input logic [7:0] pid,
                             input int unsigned len, input bit corrupt);
    logic [7:0] sum;
    logic [7:0] tgt_b;
    logic [7:0] src_b;
    logic [7:0] bb;
    tgt_b = {apd_pkg::TargetTag, tgt};
    src_b = {apd_pkg::SourceTag, src};
    sum   = apd_pkg::SofByte + tgt_b + src_b;
    if (len == 0 && !corrupt) pid = 8'h00 - sum;
    sum = sum + pid;
    rx_bytes.push_back(apd_pkg::SofByte);
    rx_bytes.push_back(tgt_b);
    rx_bytes.push_back(src_b);
    rx_bytes.push_back(pid);
    rx_bytes.push_back(8'(len));
    if (len > 0) begin
      sum = sum + 8'(len);
      for (int i = 0; i < int'(len) - 1; i++) begin
        bb = 8'($urandom);
        rx_bytes.push_back(bb);
        sum = sum + bb;
      end
      rx_bytes.push_back(corrupt ? sum + 8'($urandom_range(1, 255)) : sum);
    end
    rx_bytes.push_back(8'($urandom));
  endtask

  // idling profile follows progress through the stream
  function automatic int unsigned idle_pct(input bit sink);
    if (bytes_taken < 140) return 0;
    if (bytes_taken < 280) return sink ? 0 : 83;
    if (bytes_taken < 420) return sink ? 83 : 0;
    return 7;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        deframe_byte(s_axis_tdata);
        bytes_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (rx_bytes.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= rx_bytes.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
  end

  always @(posedge clk_i) begin
    apd_pkg::result_t got;
    apd_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser[1], m_axis_tuser[0], m_axis_tdata[PackedW-1:0]};
      if (expected_frames.size() == 0) begin
        flag_mismatch("frame word with no frame expected");
      end else begin
        want = expected_frames.pop_front();
        check_field("target_id", 64'(got.target_id), 64'(want.target_id));
        check_field("source_id", 64'(got.source_id), 64'(want.source_id));
        check_field("packet_id", 64'(got.packet_id), 64'(want.packet_id));
        check_field("payload_length", 64'(got.payload_length), 64'(want.payload_length));
        check_field("payload_low", got.payload_low, want.payload_low);
        check_field("payload_high", got.payload_high, want.payload_high);
        check_field("trailer_byte", 64'(got.trailer_byte), 64'(want.trailer_byte));
        check_field("frame_status", 64'(got.frame_status), 64'(want.frame_status));
        check_field("checksum_skipped", 64'(got.checksum_skipped),
                    64'(want.checksum_skipped));
      end
      check_field("tdata padding", 64'(m_axis_tdata[apd_pkg::DataW-1:PackedW]), 64'd0);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLim) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int unsigned frames_made;
    int unsigned kind;
    int unsigned len;
    int unsigned cut;
    logic [3:0]  src;

    // directed: idle noise, clean zero-length frame, 0xAA as a rejected target,
    // bad source, oversize length, zero length with the checksum off
    rx_bytes.push_back(8'h00);
    rx_bytes.push_back(8'hFF);
    queue_frame(4'hF, apd_pkg::CkOnNibble, 8'h00, 0, 1'b0);
    rx_bytes.push_back(apd_pkg::SofByte);
    rx_bytes.push_back(apd_pkg::SofByte);
    rx_bytes.push_back(apd_pkg::SofByte);
    rx_bytes.push_back({apd_pkg::TargetTag, 4'h0});
    rx_bytes.push_back(8'hF0);
    rx_bytes.push_back(apd_pkg::SofByte);
    rx_bytes.push_back({apd_pkg::TargetTag, 4'h0});
    rx_bytes.push_back({apd_pkg::SourceTag, apd_pkg::CkOnNibble});
    rx_bytes.push_back(8'h00);
    rx_bytes.push_back(8'(apd_pkg::MaxPayload + 1));
    queue_frame(4'h0, apd_pkg::CkOffNibble, 8'hFF, 0, 1'b1);

    frames_made = 0;
    while (rx_bytes.size() < 575 || frames_made < 36) begin
      kind = $urandom_range(0, 99);
      if (kind < 72) begin
        cut = $urandom_range(0, 99);
        src = (cut < 45) ? apd_pkg::CkOnNibble :
              (cut < 75) ? apd_pkg::CkOffNibble : 4'($urandom);
        len = ($urandom_range(0, 9) == 0) ? apd_pkg::MaxPayload :
              $urandom_range(0, apd_pkg::MaxPayload);
        queue_frame(4'($urandom), src, 8'($urandom), len, $urandom_range(0, 99) < 20);
        frames_made++;
      end else if (kind < 87) begin
        rx_bytes.push_back(apd_pkg::SofByte);
        case ($urandom_range(0, 3))
          0: rx_bytes.push_back({4'(apd_pkg::TargetTag ^ 4'($urandom_range(1, 15))),
                                 4'($urandom)});
          1: begin
            rx_bytes.push_back({apd_pkg::TargetTag, 4'($urandom)});
            rx_bytes.push_back({4'(apd_pkg::SourceTag ^ 4'($urandom_range(1, 15))),
                                4'($urandom)});
          end
          2: begin
            rx_bytes.push_back({apd_pkg::TargetTag, 4'($urandom)});
            rx_bytes.push_back({apd_pkg::SourceTag, 4'($urandom)});
            rx_bytes.push_back(8'($urandom));
            rx_bytes.push_back(8'($urandom_range(apd_pkg::MaxPayload + 1, 255)));
          end
          default: begin
            // header then a body cut short; the next bytes fall into the body
            len = $urandom_range(1, apd_pkg::MaxPayload);
            rx_bytes.push_back({apd_pkg::TargetTag, 4'($urandom)});
            rx_bytes.push_back({apd_pkg::SourceTag, 4'($urandom)});
            rx_bytes.push_back(8'($urandom));
            rx_bytes.push_back(8'(len));
            cut = $urandom_range(0, len - 1);
            for (int i = 0; i < int'(cut); i++) rx_bytes.push_back(8'($urandom));
          end
        endcase
      end else begin
        cut = $urandom_range(1, 4);
        for (int i = 0; i < int'(cut); i++) rx_bytes.push_back(8'($urandom));
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rx_bytes.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_frames.size() > 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/apd_pkg.sv
hw/rtl/apd_in_stage.sv
hw/rtl/apd_parser.sv
hw/rtl/apd_out_stage.sv
hw/rtl/addressed_packet_deframer_top.sv
verif/tb_addressed_packet_deframer_top.sv
